// ===== sv/keyframe_matrix_interpolator_core_defines.svh =====
// ---------------------------------------------------------------------------
// keyframe_matrix_interpolator_core_defines.svh
// assertion macros shared by the interpolator rtl
// ---------------------------------------------------------------------------
`ifndef KEYFRAME_MATRIX_INTERPOLATOR_CORE_DEFINES_SVH
`define KEYFRAME_MATRIX_INTERPOLATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define KMI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kmi assertion failed");
// next-cycle implication
`define KMI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kmi assertion failed");
`else
`define KMI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define KMI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/kmi_pkg.sv =====
// ---------------------------------------------------------------------------
// kmi_pkg
// types and constants of the keyframe matrix interpolator
// ---------------------------------------------------------------------------
package kmi_pkg;

    localparam int ELEMS  = 16;
    localparam int EIDX_W = 4;

    localparam logic [1:0] ACT_LOAD_TIME = 2'd0;
    localparam logic [1:0] ACT_LOAD_ELEM = 2'd1;
    localparam logic [1:0] ACT_QUERY     = 2'd2;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_CLAMP = 2'd1;
    localparam logic [1:0] STS_ABOVE = 2'd2;
    localparam logic [1:0] STS_EQUAL = 2'd3;

    localparam logic [5:0] KEY_COUNT_RESET = 6'd2;
    localparam logic [32:0] ONE_Q16 = 33'h0_0001_0000;
    localparam logic [5:0] DIV_STEPS = 6'd33;
    localparam logic [3:0] LAST_ELEM = 4'd15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_T1_RD,
        ST_T1_CHK,
        ST_DIVIDE,
        ST_EL_RD,
        ST_EL_DIFF,
        ST_EL_MLO,
        ST_EL_MHI,
        ST_EL_TERM,
        ST_EL_OUT
    } state_t;

    typedef struct packed {
        logic wr_time;
        logic wr_elem;
        logic q_start;
        logic rd_search;
        logic search_take;
        logic search_next;
        logic rd_t1;
        logic t1_take;
        logic div_step;
        logic div_fin;
        logic el_rd;
        logic el_diff;
        logic el_mlo;
        logic el_mhi;
        logic el_term;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic last_pair;
        logic zero_d;
        logic div_done;
        logic out_free;
        logic el_last;
    } sts_t;

endpackage

// ===== sv/kmi_if.sv =====
// ---------------------------------------------------------------------------
// kmi_if
// item and result channels of the keyframe matrix interpolator
// ---------------------------------------------------------------------------
interface kmi_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [4:0]         key_index;
    logic [3:0]         element_index;
    logic [15:0]        key_time;
    logic signed [31:0] element_value;
    logic [31:0]        query_time;

    modport source (output valid, action, key_index, element_index, key_time,
                    element_value, query_time, input ready);
    modport sink (input valid, action, key_index, element_index, key_time,
                  element_value, query_time, output ready);
endinterface

interface kmi_result_if;
    logic               valid;
    logic               ready;
    logic [3:0]         out_index;
    logic signed [31:0] out_value;
    logic               last;
    logic [1:0]         status;

    modport source (output valid, out_index, out_value, last, status, input ready);
    modport sink (input valid, out_index, out_value, last, status, output ready);
endinterface

// ===== sv/kmi_ctrl.sv =====
// ---------------------------------------------------------------------------
// kmi_ctrl
// sequencer: table writes, key search, weight division and per-element multiply steps
// ---------------------------------------------------------------------------
`include "keyframe_matrix_interpolator_core_defines.svh"

module kmi_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  logic [1:0]    action,
    output logic          item_ready,
    output kmi_pkg::cmd_t cmd,
    input  kmi_pkg::sts_t sts
);

    kmi_pkg::state_t state_reg;
    kmi_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kmi_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            kmi_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    unique case (action)
                        kmi_pkg::ACT_LOAD_TIME: cmd.wr_time = 1'b1;
                        kmi_pkg::ACT_LOAD_ELEM: cmd.wr_elem = 1'b1;
                        kmi_pkg::ACT_QUERY:
                        begin
                            cmd.q_start = 1'b1;
                            state_next  = kmi_pkg::ST_SRCH_RD;
                        end
                        default: ;
                    endcase
                end
            end
            kmi_pkg::ST_SRCH_RD:
            begin
                cmd.rd_search = 1'b1;
                state_next    = kmi_pkg::ST_SRCH_CMP;
            end
            kmi_pkg::ST_SRCH_CMP:
            begin
                if (sts.hit || sts.last_pair)
                begin
                    cmd.search_take = 1'b1;
                    state_next      = kmi_pkg::ST_T1_RD;
                end
                else
                begin
                    cmd.search_next = 1'b1;
                    state_next      = kmi_pkg::ST_SRCH_RD;
                end
            end
            kmi_pkg::ST_T1_RD:
            begin
                cmd.rd_t1  = 1'b1;
                state_next = kmi_pkg::ST_T1_CHK;
            end
            kmi_pkg::ST_T1_CHK:
            begin
                cmd.t1_take = 1'b1;
                state_next  = sts.zero_d ? kmi_pkg::ST_EL_RD : kmi_pkg::ST_DIVIDE;
            end
            kmi_pkg::ST_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    cmd.div_fin = 1'b1;
                    state_next  = kmi_pkg::ST_EL_RD;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            kmi_pkg::ST_EL_RD:
            begin
                cmd.el_rd  = 1'b1;
                state_next = kmi_pkg::ST_EL_DIFF;
            end
            kmi_pkg::ST_EL_DIFF:
            begin
                cmd.el_diff = 1'b1;
                state_next  = kmi_pkg::ST_EL_MLO;
            end
            kmi_pkg::ST_EL_MLO:
            begin
                cmd.el_mlo = 1'b1;
                state_next = kmi_pkg::ST_EL_MHI;
            end
            kmi_pkg::ST_EL_MHI:
            begin
                cmd.el_mhi = 1'b1;
                state_next = kmi_pkg::ST_EL_TERM;
            end
            kmi_pkg::ST_EL_TERM:
            begin
                cmd.el_term = 1'b1;
                state_next  = kmi_pkg::ST_EL_OUT;
            end
            kmi_pkg::ST_EL_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sts.el_last ? kmi_pkg::ST_IDLE : kmi_pkg::ST_EL_RD;
                end
            end
            default: state_next = kmi_pkg::ST_IDLE;
        endcase
    end

    `KMI_ASSERT_NEXT(a_query_starts_search, clk, rst_n, cmd.q_start,
                     state_reg == kmi_pkg::ST_SRCH_RD)
    `KMI_ASSERT_NEXT(a_divide_holds, clk, rst_n,
                     state_reg == kmi_pkg::ST_DIVIDE && !sts.div_done,
                     state_reg == kmi_pkg::ST_DIVIDE)
    `KMI_ASSERT_NEXT(a_out_stall_holds, clk, rst_n,
                     state_reg == kmi_pkg::ST_EL_OUT && !sts.out_free,
                     state_reg == kmi_pkg::ST_EL_OUT)

endmodule

// ===== sv/kmi_datapath.sv =====
// ---------------------------------------------------------------------------
// kmi_datapath
// key tables, search compare, serial divider and split multiplier
// ---------------------------------------------------------------------------
`include "keyframe_matrix_interpolator_core_defines.svh"

module kmi_datapath
#(
    parameter int MAX_KEYS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  kmi_pkg::cmd_t      cmd,
    output kmi_pkg::sts_t      sts,
    input  logic               cfg_we,
    input  logic [5:0]         cfg_wdata,
    input  logic [4:0]         key_index,
    input  logic [3:0]         element_index,
    input  logic [15:0]        key_time,
    input  logic signed [31:0] element_value,
    input  logic [31:0]        query_time,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         out_index,
    output logic signed [31:0] out_value,
    output logic               last,
    output logic [1:0]         status
);

    localparam int KW    = $clog2(MAX_KEYS);
    localparam int AW    = KW + kmi_pkg::EIDX_W;
    localparam int DEPTH = MAX_KEYS * kmi_pkg::ELEMS;

    logic [5:0]         key_count_reg;
    logic [15:0]        time_mem [MAX_KEYS];
    logic [31:0]        mat_mem  [DEPTH];
    logic [15:0]        time_q_reg;
    logic [31:0]        m0_q_reg;
    logic [31:0]        m1_q_reg;
    logic [31:0]        tq_reg;
    logic [KW-1:0]      last_idx_reg;
    logic [KW-1:0]      j_reg;
    logic [3:0]         e_reg;
    logic [15:0]        t0_reg;
    logic [1:0]         status_reg;
    logic [15:0]        rem_reg;
    logic [32:0]        quo_reg;
    logic [15:0]        dvsr_reg;
    logic [5:0]         dcount_reg;
    logic               r_neg_reg;
    logic [32:0]        a_reg;
    logic               t_neg_reg;
    logic [49:0]        p_lo_reg;
    logic [48:0]        p_hi_reg;
    logic signed [51:0] term_reg;
    logic               out_valid_reg;
    logic [3:0]         out_index_reg;
    logic signed [31:0] out_value_reg;
    logic               out_last_reg;
    logic [1:0]         out_status_reg;

    logic               key_ok;
    logic [KW-1:0]      wr_key;
    logic [KW-1:0]      j_plus;
    logic [KW-1:0]      taddr;
    logic [KW-1:0]      last_idx_next;
    logic signed [33:0] num;
    logic               num_neg;
    logic [33:0]        num_abs;
    logic signed [16:0] dsub;
    logic [16:0]        dsub_abs;
    logic [16:0]        div_shift;
    logic               div_ge;
    logic [16:0]        div_diff;
    logic signed [32:0] ediff;
    logic [32:0]        ediff_abs;
    logic [66:0]        psum;
    logic [51:0]        tmag;
    logic signed [51:0] vsum;
    logic signed [31:0] vsat;
    logic               out_free;

    assign key_ok = 32'(key_index) < 32'(MAX_KEYS);
    assign wr_key = KW'(key_index);
    assign j_plus = KW'(j_reg + 1'b1);
    assign taddr  = cmd.rd_t1 ? j_plus : j_reg;

    // clamp key count to [2, MAX_KEYS] and keep count-2 as the last pair start
    always_comb
    begin
        if (key_count_reg < 6'd2)
        begin
            last_idx_next = '0;
        end
        else if (32'(key_count_reg) > 32'(MAX_KEYS))
        begin
            last_idx_next = KW'(MAX_KEYS - 2);
        end
        else
        begin
            last_idx_next = KW'(key_count_reg - 6'd2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= kmi_pkg::KEY_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            key_count_reg <= cfg_wdata;
        end
    end

    // key time table, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_time && key_ok)
        begin
            time_mem[wr_key] <= key_time;
        end
        if (cmd.rd_search || cmd.rd_t1)
        begin
            time_q_reg <= time_mem[taddr];
        end
    end

    // matrix table, one write and two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.wr_elem && key_ok)
        begin
            mat_mem[AW'({wr_key, element_index})] <= element_value;
        end
        if (cmd.el_rd)
        begin
            m0_q_reg <= mat_mem[AW'({j_reg, e_reg})];
            m1_q_reg <= mat_mem[AW'({j_plus, e_reg})];
        end
    end

    // weight numerator and key spacing
    assign num      = $signed({2'b00, time_q_reg, 16'h0000}) - $signed({2'b00, tq_reg})
                      - 34'sd65536;
    assign num_neg  = num[33];
    assign num_abs  = num_neg ? 34'(-num) : 34'(num);
    assign dsub     = $signed({1'b0, time_q_reg}) - $signed({1'b0, t0_reg});
    assign dsub_abs = dsub[16] ? 17'(-dsub) : 17'(dsub);

    // one quotient bit per step
    assign div_shift = {rem_reg, quo_reg[32]};
    assign div_ge    = div_shift >= {1'b0, dvsr_reg};
    assign div_diff  = div_shift - {1'b0, dvsr_reg};

    assign ediff     = $signed({m0_q_reg[31], m0_q_reg}) - $signed({m1_q_reg[31], m1_q_reg});
    assign ediff_abs = ediff[32] ? 33'(-ediff) : 33'(ediff);

    assign psum = {17'd0, p_lo_reg} + {1'b0, p_hi_reg, 17'd0};
    assign tmag = {1'b0, psum[66:16]};

    assign vsum = $signed({{20{m1_q_reg[31]}}, m1_q_reg}) + term_reg;

    always_comb
    begin
        if (vsum > 52'sd2147483647)
        begin
            vsat = 32'sh7FFF_FFFF;
        end
        else if (vsum < -52'sd2147483648)
        begin
            vsat = 32'sh8000_0000;
        end
        else
        begin
            vsat = vsum[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_start)
        begin
            tq_reg       <= query_time;
            last_idx_reg <= last_idx_next;
            j_reg        <= '0;
            e_reg        <= '0;
            status_reg   <= kmi_pkg::STS_OK;
        end
        if (cmd.search_next)
        begin
            j_reg <= j_plus;
        end
        if (cmd.search_take)
        begin
            t0_reg <= time_q_reg;
            if (!sts.hit)
            begin
                status_reg <= kmi_pkg::STS_CLAMP;
            end
        end
        if (cmd.t1_take)
        begin
            rem_reg <= '0;
            if (sts.zero_d)
            begin
                quo_reg    <= kmi_pkg::ONE_Q16;
                r_neg_reg  <= 1'b0;
                dcount_reg <= '0;
                if (status_reg == kmi_pkg::STS_OK)
                begin
                    status_reg <= kmi_pkg::STS_EQUAL;
                end
            end
            else
            begin
                quo_reg    <= num_abs[32:0];
                dvsr_reg   <= dsub_abs[15:0];
                r_neg_reg  <= num_neg ^ dsub[16];
                dcount_reg <= kmi_pkg::DIV_STEPS;
            end
        end
        if (cmd.div_step)
        begin
            rem_reg    <= div_ge ? div_diff[15:0] : div_shift[15:0];
            quo_reg    <= {quo_reg[31:0], div_ge};
            dcount_reg <= dcount_reg - 6'd1;
        end
        if (cmd.div_fin && !r_neg_reg && quo_reg > kmi_pkg::ONE_Q16
            && status_reg == kmi_pkg::STS_OK)
        begin
            status_reg <= kmi_pkg::STS_ABOVE;
        end
        if (cmd.el_diff)
        begin
            a_reg     <= ediff_abs;
            t_neg_reg <= ediff[32] ^ r_neg_reg;
        end
        if (cmd.el_mlo)
        begin
            p_lo_reg <= a_reg * quo_reg[16:0];
        end
        if (cmd.el_mhi)
        begin
            p_hi_reg <= a_reg * quo_reg[32:17];
        end
        if (cmd.el_term)
        begin
            term_reg <= t_neg_reg ? -$signed(tmag) : $signed(tmag);
        end
        if (cmd.out_load)
        begin
            e_reg          <= e_reg + 4'd1;
            out_index_reg  <= e_reg;
            out_value_reg  <= vsat;
            out_last_reg   <= e_reg == kmi_pkg::LAST_ELEM;
            out_status_reg <= status_reg;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.hit       = time_q_reg >= tq_reg[31:16];
    assign sts.last_pair = j_reg == last_idx_reg;
    assign sts.zero_d    = time_q_reg == t0_reg;
    assign sts.div_done  = dcount_reg == '0;
    assign sts.out_free  = out_free;
    assign sts.el_last   = e_reg == kmi_pkg::LAST_ELEM;

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_value = out_value_reg;
    assign last      = out_last_reg;
    assign status    = out_status_reg;

    `KMI_ASSERT_IMPL(a_load_only_when_free, clk, rst_n, cmd.out_load, out_free)
    `KMI_ASSERT_IMPL(a_search_in_range, clk, rst_n, cmd.search_next,
                     j_reg != last_idx_reg)
    `KMI_ASSERT_IMPL(a_last_on_final, clk, rst_n, out_valid_reg && out_last_reg,
                     out_index_reg == kmi_pkg::LAST_ELEM)

endmodule

// ===== sv/keyframe_matrix_interpolator_core.sv =====
// ---------------------------------------------------------------------------
// keyframe_matrix_interpolator_core
// linear interpolation between two 4x4 keyframe matrices
// ---------------------------------------------------------------------------
// Holds up to MAX_KEYS animation keys (a 16-bit frame time plus a 4x4 Q16.16
// matrix each). A load item writes one key time or one matrix element. A
// query item with frame time t (Q16.16) searches the keys in order for the
// first key i with time at least floor(t), then forms the weight
// r = (time[i+1]-(t+1))/(time[i+1]-time[i]) in a bit-serial divider (33
// steps, skipped for equal key times) and sends 16 results, one per matrix
// element, each passing through the table read, difference, two half-width
// multiplies and the sum. The block takes one item at a time, but the next
// item is accepted while the final result still sits in the output register.
// Status on every result: 0 ok, 1 search ran past the last pair and was
// clamped to pair key_count-2, 2 weight above one (not clamped), 3 equal key
// times (weight taken as one). The user must write key_count through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce
// this. Values below two act as two and values above MAX_KEYS as MAX_KEYS.
// Tables have no reset value.
// ---------------------------------------------------------------------------
module keyframe_matrix_interpolator_core
#(
    parameter int MAX_KEYS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    kmi_item_if.sink            item_ch,
    kmi_result_if.source        result_ch,
    input  logic                cfg_we,
    input  logic [5:0]          cfg_wdata
);

    // command and status bundles between sequencer and datapath
    kmi_pkg::cmd_t cmd;
    kmi_pkg::sts_t sts;
    logic          item_ready;

    // sequencer: ready only when idle, steps the search, divide and elements
    kmi_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_ch.valid),
        .action     (item_ch.action),
        .item_ready (item_ready),
        .cmd        (cmd),
        .sts        (sts)
    );

    assign item_ch.ready = item_ready;

    // tables, divider, multipliers and the output register
    kmi_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .key_index     (item_ch.key_index),
        .element_index (item_ch.element_index),
        .key_time      (item_ch.key_time),
        .element_value (item_ch.element_value),
        .query_time    (item_ch.query_time),
        .out_valid     (result_ch.valid),
        .out_ready     (result_ch.ready),
        .out_index     (result_ch.out_index),
        .out_value     (result_ch.out_value),
        .last          (result_ch.last),
        .status        (result_ch.status)
    );

endmodule

// ===== dv/kmi_test_if.sv =====
// ---------------------------------------------------------------------------
// kmi_test_if
// package of testbench types for the interpolator regression
// ---------------------------------------------------------------------------
package kmi_test_pkg;

    import kmi_pkg::*;

    // one input item of the interpolator
    typedef struct {
        logic [1:0]         action;
        logic [4:0]         key_index;
        logic [3:0]         element_index;
        logic [15:0]        key_time;
        logic signed [31:0] element_value;
        logic [31:0]        query_time;
    } key_item_t;

    // one interpolated element
    typedef struct {
        logic [3:0]         out_index;
        logic signed [31:0] out_value;
        logic               last;
        logic [1:0]         status;
    } elem_result_t;

endpackage

// ===== dv/keyframe_matrix_interpolator_core_test.sv =====
// ---------------------------------------------------------------------------
// keyframe_matrix_interpolator_core_test
// self-checking regression of the keyframe matrix interpolator
// ---------------------------------------------------------------------------
// Loads key times and matrices, runs a directed table of queries and then
// random key tables and queries under several key counts. Every element sent
// back is checked against an in-bench interpolation of the same tables. Both
// channels idle at random between items.
// ---------------------------------------------------------------------------
module keyframe_matrix_interpolator_core_test;

    import kmi_pkg::*;
    import kmi_test_pkg::*;

    localparam int NKEYS     = 32;
    localparam int CYC_LIMIT = 400000;

    // action code with no meaning, the block drops it
    localparam logic [1:0] ACT_NONE = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [5:0] cfg_wdata;

    kmi_item_if   item_ch();
    kmi_result_if result_ch();

    keyframe_matrix_interpolator_core #(.MAX_KEYS(NKEYS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_ch   (item_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // shadow copy of the key tables and the key count
    logic [15:0]    key_times [NKEYS];
    logic [31:0]    key_mats  [NKEYS*ELEMS];
    bit [ELEMS-1:0] elem_seen [NKEYS];
    logic [5:0]     key_count_shadow;

    elem_result_t pending_elems[$];

    int mismatches;
    int elems_checked;
    int queries_sent;
    int cycle_count;
    int rdy_wait = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // exact trunc(diff * r / 65536) toward zero
    function automatic longint scale_term(longint diff, longint weight);
        logic signed [127:0] prod;
        logic [127:0] mag;
        prod = 128'(signed'(diff)) * 128'(signed'(weight));
        mag  = prod < 0 ? -prod : prod;
        mag  = mag >> 16;
        return prod < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    // key pair a query lands on under the current key count
    function automatic int query_pair(logic [31:0] t);
        int n, k;
        n = key_count_shadow;
        if (n < 2) n = 2;
        if (n > NKEYS) n = NKEYS;
        for (k = 0; k < n; k++)
            if (key_times[k] >= t[31:16]) break;
        if (k > n - 2) k = n - 2;
        return k;
    endfunction

    // interpolate one query against the shadow tables, queue 16 elements
    function automatic void interpolate_query(logic [31:0] t);
        int n, k, e;
        logic [1:0] sts;
        longint t0, t1, num, d, w, m0, m1, v;
        elem_result_t res;
        n = key_count_shadow;
        if (n < 2) n = 2;
        if (n > NKEYS) n = NKEYS;
        for (k = 0; k < n; k++)
            if (key_times[k] >= t[31:16]) break;
        sts = STS_OK;
        if (k > n - 2)
        begin
            k = n - 2;
            sts = STS_CLAMP;
        end
        t0 = key_times[k];
        t1 = key_times[k+1];
        num = t1 * 65536 - longint'(t) - 65536;
        d = t1 - t0;
        if (d == 0)
        begin
            w = 65536;
            if (sts == STS_OK) sts = STS_EQUAL;
        end
        else
        begin
            w = num / d;
            if (w > 65536 && sts == STS_OK) sts = STS_ABOVE;
        end
        for (e = 0; e < ELEMS; e++)
        begin
            m0 = longint'(signed'(key_mats[k*ELEMS+e]));
            m1 = longint'(signed'(key_mats[(k+1)*ELEMS+e]));
            v = m1 + scale_term(m0 - m1, w);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            res.out_index = 4'(e);
            res.out_value = 32'(v);
            res.last      = (e == ELEMS - 1);
            res.status    = sts;
            pending_elems = {pending_elems, res};
        end
    endfunction

    // apply an accepted item to the shadow state
    function automatic void track_item(key_item_t it);
        case (it.action)
            ACT_LOAD_TIME: key_times[it.key_index] = it.key_time;
            ACT_LOAD_ELEM:
            begin
                key_mats[it.key_index*ELEMS+it.element_index] = it.element_value;
                elem_seen[it.key_index][it.element_index] = 1'b1;
            end
            ACT_QUERY:
            begin
                interpolate_query(it.query_time);
                queries_sent++;
            end
            default: ;
        endcase
    endfunction

    // one item through the handshake, with a random gap before it
    task automatic send_item(key_item_t it);
        int gap;
        gap = $urandom_range(3) == 0 ? 0 : $urandom_range(13);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.action        <= it.action;
        item_ch.key_index     <= it.key_index;
        item_ch.element_index <= it.element_index;
        item_ch.key_time      <= it.key_time;
        item_ch.element_value <= it.element_value;
        item_ch.query_time    <= it.query_time;
        do @(posedge clk); while (!item_ch.ready);
        track_item(it);
    endtask

    task automatic send_time(int k, logic [15:0] tv);
        key_item_t it;
        it = '{ACT_LOAD_TIME, 5'(k), 4'($urandom), tv, $urandom, $urandom};
        send_item(it);
    endtask

    task automatic send_elem(int k, int e, logic [31:0] ev);
        key_item_t it;
        it = '{ACT_LOAD_ELEM, 5'(k), 4'(e), 16'($urandom), ev, $urandom};
        send_item(it);
    endtask

    task automatic send_query(logic [31:0] t);
        key_item_t it;
        it = '{ACT_QUERY, 5'($urandom), 4'($urandom), 16'($urandom), $urandom, t};
        send_item(it);
    endtask

    // drop valid, idle until every element is back, then let the block settle
    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_elems.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_key_count(logic [5:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        key_count_shadow = v;
    endtask

    // every key time: mostly ascending, some repeats and some jumps
    task automatic fill_times();
        int k;
        logic [15:0] tv;
        tv = 16'($urandom_range(2000));
        for (k = 0; k < NKEYS; k++)
        begin
            case ($urandom_range(7))
                0: ;    // same time as the key before
                1: tv = 16'($urandom);
                default: tv = tv + 16'($urandom_range(3000));
            endcase
            send_time(k, tv);
        end
    endtask

    // one key matrix: mixed extremes and random values
    task automatic fill_mat(int k);
        int e;
        for (e = 0; e < ELEMS; e++)
            case ($urandom_range(7))
                0: send_elem(k, e, 32'h7fff_ffff);
                1: send_elem(k, e, 32'h8000_0000);
                2: send_elem(k, e, 32'($signed(17'($urandom))));
                default: send_elem(k, e, $urandom);
            endcase
    endtask

    // query time near the loaded pairs, or anywhere
    function automatic logic [31:0] draw_query();
        case ($urandom_range(4))
            0: return $urandom;
            1: return {key_times[$urandom_range(2)] - 16'($urandom_range(40)),
                       16'($urandom)};
            2: return {key_times[NKEYS - 2 + $urandom_range(1)] + 16'($urandom_range(1)),
                       16'($urandom)};
            3: return {16'($urandom_range(65535)), 16'hffff};
            default: return {16'($urandom_range(600)), 16'($urandom)};
        endcase
    endfunction

    // result side: random wait per item, compare against the oldest expectation
    always @(posedge clk)
    begin
        elem_result_t want;
        int w;
        if (result_ch.valid && result_ch.ready)
        begin
            if (pending_elems.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected element idx=%0d val=%h",
                             result_ch.out_index, result_ch.out_value);
            end
            else
            begin
                want = pending_elems.pop_front();
                elems_checked++;
                if (result_ch.out_index !== want.out_index
                    || result_ch.out_value !== want.out_value
                    || result_ch.last !== want.last
                    || result_ch.status !== want.status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: want idx=%0d val=%h last=%b sts=%0d,",
                                  " got idx=%0d val=%h last=%b sts=%0d"},
                                 want.out_index, want.out_value, want.last,
                                 want.status, result_ch.out_index,
                                 result_ch.out_value, result_ch.last,
                                 result_ch.status);
                end
            end
            w = ($urandom_range(3) == 0) ? 0 : $urandom_range(13);
            rdy_wait        <= w;
            result_ch.ready <= (w == 0);
        end
        else if (rdy_wait > 1)
        begin
            rdy_wait <= rdy_wait - 1;
        end
        else
        begin
            rdy_wait        <= 0;
            result_ch.ready <= 1'b1;
        end
    end

    // directed queries; expected status typed in where it is obvious
    typedef struct {
        logic [31:0] t;
        bit          known;
        logic [1:0]  sts;
    } query_row_t;

    query_row_t directed_rows[] = '{
        '{32'h0000_0000, 1'b0, STS_OK},      // on the first key
        '{32'h0000_ffff, 1'b0, STS_OK},
        '{32'h0005_8000, 1'b0, STS_OK},      // between keys
        '{32'h0014_0000, 1'b0, STS_OK},      // past the last pair, clamped
        '{32'hffff_ffff, 1'b1, STS_CLAMP},   // ran past every key
        '{32'h0032_0000, 1'b1, STS_CLAMP}
    };

    initial
    begin
        int i, k, e, tries;
        logic [31:0] tq;
        key_item_t junk;
        logic [5:0] counts[] = '{6'd2, 6'd32, 6'd0, 6'd63, 6'd1, 6'd5, 6'd17};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.action = ACT_LOAD_TIME;
        item_ch.key_index = '0;
        item_ch.element_index = '0;
        item_ch.key_time = '0;
        item_ch.element_value = '0;
        item_ch.query_time = '0;
        result_ch.ready = 1'b0;
        mismatches = 0;
        elems_checked = 0;
        queries_sent = 0;
        cycle_count = 0;
        key_count_shadow = KEY_COUNT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: three keys, reset key count of two
        send_time(0, 16'd0);
        send_time(1, 16'd10);
        send_time(2, 16'd10);
        for (k = 0; k < 3; k++)
            for (e = 0; e < ELEMS; e++)
                send_elem(k, e, e[0] ? 32'h7fff_ffff : 32'h8000_0000);
        junk = '{ACT_NONE, 5'd1, 4'd2, 16'hffff, 32'h1234_5678, 32'h0}; // unknown action
        send_item(junk);
        for (i = 0; i < directed_rows.size(); i++)
        begin
            send_query(directed_rows[i].t);
            if (directed_rows[i].known
                && pending_elems[pending_elems.size()-1].status !== directed_rows[i].sts)
            begin
                mismatches++;
                $display("directed row %0d: predicted status %0d, table says %0d", i,
                         pending_elems[pending_elems.size()-1].status, directed_rows[i].sts);
            end
        end
        drain();
        // equal key times on pair one
        set_key_count(6'd3);
        send_query(32'h000a_0000);
        send_query(32'h0009_0000);
        drain();

        // random phase: fresh key times, new matrices on keys 0, NKEYS-2 and NKEYS-1
        fill_times();
        fill_mat(0);
        fill_mat(NKEYS - 2);
        fill_mat(NKEYS - 1);
        drain();

        // queries over several key counts, only on pairs with loaded matrices
        foreach (counts[c])
        begin
            set_key_count(counts[c]);
            for (i = 0; i < 4; i++)
            begin
                tries = 0;
                do
                begin
                    tq = draw_query();
                    k  = query_pair(tq);
                    tries++;
                end
                while (!(&elem_seen[k] && &elem_seen[k+1]) && tries < 8);
                // fall back to a query on the first pair
                if (!(&elem_seen[k] && &elem_seen[k+1]))
                    tq = '0;
                send_query(tq);
            end
            drain();
        end

        $display("covered %0d queries, %0d elements checked, key counts 0 to 63",
                 queries_sent, elems_checked);
        if (mismatches == 0 && pending_elems.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/kmi_pkg.sv
sv/kmi_if.sv
sv/kmi_ctrl.sv
sv/kmi_datapath.sv
sv/keyframe_matrix_interpolator_core.sv
dv/kmi_test_if.sv
dv/keyframe_matrix_interpolator_core_test.sv
